// ----- hdl/scalar_kalman_smoother_assert.svh -----
// Assertion shorthands shared by the smoother RTL.
// Each expects clk and rst in scope.
`ifndef SCALAR_KALMAN_SMOOTHER_ASSERT_SVH
`define SCALAR_KALMAN_SMOOTHER_ASSERT_SVH

// Same-cycle implication.
`define SKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sks assertion failed");

// Next-cycle implication.
`define SKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sks assertion failed");

`endif

// ----- hdl/sks_pkg.sv -----
package sks_pkg;

  localparam int MEAS_W  = 32;
  localparam int COV_W   = 24;
  localparam int CHAN_W  = 3;
  localparam int GAIN_W  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [COV_W-1:0]  COV_MAX = {COV_W{1'b1}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};
  localparam logic [GAIN_W:0]   GAIN_ONE = {1'b1, {GAIN_W{1'b0}}};

  // Register reset values
  localparam logic [COV_W-1:0]  PROCESS_NOISE_RST = 24'd66;
  localparam logic [COV_W-1:0]  MEASURE_NOISE_RST = 24'd6554;
  localparam logic [COV_W-1:0]  ERROR_INIT_RST    = 24'd6554;
  localparam logic [MEAS_W-1:0] ESTIMATE_INIT_RST = 32'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_INIT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESTIMATE_INIT = 2'd3;

  typedef struct packed {
    logic [CHAN_W-1:0]        channel;
    logic signed [MEAS_W-1:0] measurement;
  } sample_t;

  typedef struct packed {
    logic [CHAN_W-1:0]        channel_out;
    logic signed [MEAS_W-1:0] estimate;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // capture sample beat
    logic predict;  // P1 = sat(P + Q), fetch X
    logic sum;      // S = sat(P1 + R), diff = m - X, seed divider
    logic div;      // one restoring divide step
    logic gain;     // select K
    logic mul;      // both products
    logic commit;   // write back state, load result register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ch_ok;    // captured channel is in range
  } status_t;

endpackage

// ----- hdl/sks_stream_if.sv -----
interface sks_stream_if #(
  parameter type payload_t = logic [0:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sks_ctrl.sv -----
module sks_ctrl
  import sks_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    sample_valid,
  output logic    sample_ready,
  output logic    result_valid,
  input  logic    result_ready,
  input  status_t status,
  output cmd_t    cmd
);

`include "scalar_kalman_smoother_assert.svh"

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_PREDICT = 3'd1;
  localparam logic [ST_W-1:0] ST_SUM     = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV     = 3'd3;
  localparam logic [ST_W-1:0] ST_GAIN    = 3'd4;
  localparam logic [ST_W-1:0] ST_MUL     = 3'd5;
  localparam logic [ST_W-1:0] ST_DONE    = 3'd6;

  localparam int CNT_W = $clog2(GAIN_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GAIN_W - 1);

  logic [ST_W-1:0]  state, state_next;
  logic [CNT_W-1:0] div_cnt;
  logic             result_free;

  assign result_free  = !result_valid || result_ready;
  assign sample_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PREDICT;
        end
      end
      ST_PREDICT: begin
        cmd.predict = 1'b1;
        state_next  = status.ch_ok ? ST_SUM : ST_DONE;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (div_cnt == CNT_LAST) begin
          state_next = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (result_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      div_cnt      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= cmd.commit || (result_valid && !result_ready);
      if (cmd.sum) begin
        div_cnt <= '0;
      end else if (cmd.div) begin
        div_cnt <= div_cnt + 1'b1;
      end
    end
  end

  `SKS_ASSERT_NOW(a_no_overwrite, cmd.commit, !result_valid || result_ready)
  `SKS_ASSERT_NEXT(a_one_item, sample_valid && sample_ready, !sample_ready)
  `SKS_ASSERT_NOW(a_result_from_done, $rose(result_valid), $past(state) == ST_DONE)

endmodule

// ----- hdl/sks_dp.sv -----
module sks_dp
  import sks_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  sample_t               sample,
  output result_t               result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIFF_W = MEAS_W + 1;
  localparam int PX_W = GAIN_W + 1 + DIFF_W;
  localparam int PP_W = GAIN_W + 1 + COV_W;

  logic [COV_W-1:0]  process_noise, measure_noise, error_init;
  logic [MEAS_W-1:0] estimate_init;

  logic signed [MEAS_W-1:0] estimates [CHANNELS];
  logic [COV_W-1:0]         covariances [CHANNELS];

  logic [CHAN_W-1:0]        ch;
  logic signed [MEAS_W-1:0] meas;
  logic                     ch_ok;
  logic [IDX_W-1:0]         idx;

  logic signed [MEAS_W-1:0] x;
  logic [COV_W-1:0]         p1, s;
  logic signed [DIFF_W-1:0] diff;
  logic [COV_W-1:0]         rem;
  logic [GAIN_W-1:0]        quo, k;
  logic signed [PX_W-1:0]   prod_x;
  logic [PP_W-1:0]          prod_p;

  logic [COV_W:0]           p1_sum, s_sum, rem_dbl, rem_sub;
  logic signed [MEAS_W-1:0] x_new;
  logic [COV_W-1:0]         p_new;

  assign idx          = IDX_W'(ch);
  assign status.ch_ok = ch_ok;

  assign p1_sum  = {1'b0, covariances[idx]} + {1'b0, process_noise};
  assign s_sum   = {1'b0, p1} + {1'b0, measure_noise};
  assign rem_dbl = {rem, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, s};
  // Floor shift: arithmetic >>> 16, low 32 bits are enough since X_new fits.
  assign x_new   = x + prod_x[GAIN_W +: MEAS_W];
  assign p_new   = prod_p[GAIN_W +: COV_W];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      error_init    <= ERROR_INIT_RST;
      estimate_init <= ESTIMATE_INIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PROCESS_NOISE: process_noise <= cfg_data[COV_W-1:0];
        CFG_MEASURE_NOISE: measure_noise <= cfg_data[COV_W-1:0];
        CFG_ERROR_INIT:    error_init    <= cfg_data[COV_W-1:0];
        CFG_ESTIMATE_INIT: estimate_init <= cfg_data[MEAS_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-channel state: reload on either init write, update on commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        estimates[i]   <= ESTIMATE_INIT_RST;
        covariances[i] <= ERROR_INIT_RST;
      end
    end else if (cfg_write && cfg_index == CFG_ERROR_INIT) begin
      for (int i = 0; i < CHANNELS; i++) begin
        estimates[i]   <= estimate_init;
        covariances[i] <= cfg_data[COV_W-1:0];
      end
    end else if (cfg_write && cfg_index == CFG_ESTIMATE_INIT) begin
      for (int i = 0; i < CHANNELS; i++) begin
        estimates[i]   <= cfg_data[MEAS_W-1:0];
        covariances[i] <= error_init;
      end
    end else if (cmd.commit && ch_ok) begin
      estimates[idx]   <= x_new;
      covariances[idx] <= p_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_ok <= 1'b0;
    end else if (cmd.load) begin
      ch_ok <= ({29'd0, sample.channel} < 32'(CHANNELS));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch   <= sample.channel;
      meas <= sample.measurement;
    end
    if (cmd.predict) begin
      p1 <= p1_sum[COV_W] ? COV_MAX : p1_sum[COV_W-1:0];
      x  <= estimates[idx];
    end
    if (cmd.sum) begin
      s    <= s_sum[COV_W] ? COV_MAX : s_sum[COV_W-1:0];
      diff <= {meas[MEAS_W-1], meas} - {x[MEAS_W-1], x};
      rem  <= p1;
      quo  <= '0;
    end
    if (cmd.div) begin
      if (!rem_sub[COV_W]) begin
        rem <= rem_sub[COV_W-1:0];
        quo <= {quo[GAIN_W-2:0], 1'b1};
      end else begin
        rem <= rem_dbl[COV_W-1:0];
        quo <= {quo[GAIN_W-2:0], 1'b0};
      end
    end
    if (cmd.gain) begin
      if (s == '0) begin
        k <= '0;
      end else if (p1 == s) begin
        k <= GAIN_MAX;
      end else begin
        k <= quo;
      end
    end
    if (cmd.mul) begin
      prod_x <= PX_W'($signed({1'b0, k})) * PX_W'(diff);
      prod_p <= PP_W'(GAIN_ONE - {1'b0, k}) * PP_W'(p1);
    end
    if (cmd.commit) begin
      result.channel_out <= ch;
      result.estimate    <= ch_ok ? x_new : '0;
    end
  end

endmodule

// ----- hdl/scalar_kalman_smoother.sv -----
// A sample beat for a valid channel passes through predict, sum, the restoring gain
// divide, gain select and multiply before commit; a channel at or above CHANNELS goes
// from predict straight to commit. Only one sample is in flight: a new beat is taken only
// while idle. A result still held at the next commit stalls the sequencer until the
// result register frees. Reset (rst, synchronous, active high): registers take reset
// values; every channel reloads estimate 0, covariance 6554.
module scalar_kalman_smoother
  import sks_pkg::*;
#(
  parameter int CHANNELS = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  sks_stream_if.sink            samples,
  sks_stream_if.source          results,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Command and status between the sequencer and the arithmetic.
  cmd_t    cmd;
  status_t status;
  sample_t sample;
  result_t result;

  // The sample payload is taken only on the load command, so it may move freely
  // while ready is low.
  assign sample          = samples.payload;
  assign results.payload = result;

  // Sequencer: capture the beat, predict, sum, divide sixteen steps, pick the
  // gain, multiply, then commit once the result register is free. The result
  // register lets the next sample beat land while the previous result waits.
  sks_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (samples.valid),
    .sample_ready (samples.ready),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: configuration registers, per-channel estimate and covariance,
  // shared divider and the two gain products.
  sks_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .sample    (sample),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
